// File: rtl/binary_to_decimal_ascii_unit_assert.svh
// Assertion macros used by the converter's checker file.
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define B2DA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("converter check failed");

// Next-cycle implication, disabled during reset.
`define B2DA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("converter check failed");

`endif

// File: rtl/b2da_pkg.sv
// Shared widths and character codes of the binary to decimal ASCII converter.
package b2da_pkg;

  localparam int VALUE_W = 32;
  localparam int DIGITS  = 10;
  localparam int BCD_W   = 4 * DIGITS;
  localparam int CHAR_W  = 6;
  localparam int POS_W   = 4;
  localparam int CNT_W   = 5;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 6'd57;
  localparam logic [CHAR_W-1:0] ASCII_POINT = 6'd46;

  typedef logic [BCD_W-1:0] bcd_t;

endpackage

// File: rtl/b2da_dabble_step.sv
// One shift-and-add-3 step of the binary to BCD conversion.
module b2da_dabble_step
  import b2da_pkg::*;
(
  input  bcd_t bcd_in,
  input  logic bit_in,
  output bcd_t bcd_out
);

  bcd_t adjusted;

  // Add 3 to every digit of 5 or more, then shift in the next binary bit.
  always_comb begin
    adjusted = bcd_in;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_in[4*d +: 4] >= 4'd5) begin
        adjusted[4*d +: 4] = bcd_in[4*d +: 4] + 4'd3;
      end
    end
  end

  assign bcd_out = {adjusted[BCD_W-2:0], bit_in};

endmodule

// File: rtl/binary_to_decimal_ascii_unit.sv
// Top level of the binary to decimal ASCII converter: sequencer and output register.
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------
//  input   | item_valid / item_stall | value[31:0], two_decimals
//  output  | char_valid / char_stall | character[5:0], last
//
// One word is taken in IDLE, shifted through the shared shift-and-add-3 step in
// CONVERT (one binary bit per cycle), searched for its leading digit in FIND, then
// emitted in EMIT one character per cycle (1 to 11) while the output does not stall.
// item_stall is high from the accept until the last character is loaded.
// Reset clears the sequencer and the output valid; data registers keep no reset value.
// A stall on the output holds the current character and pauses the emitter; the
// next word is taken as soon as the last character of a number is loaded.
module binary_to_decimal_ascii_unit
  import b2da_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [VALUE_W-1:0]  value,
  input  logic                two_decimals,
  input  logic                item_valid,
  output logic                item_stall,
  output logic [CHAR_W-1:0]   character,
  output logic                last,
  output logic                char_valid,
  input  logic                char_stall
);

  typedef enum logic [1:0] {
    IDLE,
    CONVERT,
    FIND,
    EMIT
  } state_t;

  state_t               state;
  logic [VALUE_W-1:0]   bin;
  bcd_t                 bcd;
  bcd_t                 bcd_next;
  logic [CNT_W-1:0]     cnt;
  logic                 point_mode;
  logic                 point_pending;
  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     lead_pos;
  logic [3:0]           digit;
  logic                 accept;
  logic                 load;

  // Shared arithmetic unit: one double-dabble step per cycle.
  b2da_dabble_step u_step (
    .bcd_in  (bcd),
    .bit_in  (bin[VALUE_W-1]),
    .bcd_out (bcd_next)
  );

  // Leading nonzero digit; a lone zero prints one digit, point mode at least three.
  always_comb begin
    lead_pos = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[4*d +: 4] != 4'd0) begin
        lead_pos = POS_W'(d);
      end
    end
    if (point_mode && lead_pos < POS_W'(2)) begin
      lead_pos = POS_W'(2);
    end
  end

  assign digit      = bcd[4*pos +: 4];
  assign item_stall = (state != IDLE);
  assign accept     = item_valid && !item_stall;
  // Load a new character whenever the output register is empty or being taken.
  assign load       = (state == EMIT) && (!char_valid || !char_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      char_valid    <= 1'b0;
      point_pending <= 1'b0;
      cnt           <= '0;
    end else begin
      // Drop the output word once taken, unless a new one replaces it.
      if (load) begin
        char_valid <= 1'b1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (accept) begin
            bin           <= value;
            bcd           <= '0;
            point_mode    <= two_decimals;
            point_pending <= 1'b0;
            cnt           <= '0;
            state         <= CONVERT;
          end
        end
        CONVERT: begin
          bcd <= bcd_next;
          bin <= {bin[VALUE_W-2:0], 1'b0};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(VALUE_W - 1)) begin
            state <= FIND;
          end
        end
        FIND: begin
          pos   <= lead_pos;
          state <= EMIT;
        end
        EMIT: begin
          if (load) begin
            if (point_pending) begin
              // Two digits always follow the point.
              character     <= ASCII_POINT;
              last          <= 1'b0;
              point_pending <= 1'b0;
            end else begin
              character     <= ASCII_ZERO + CHAR_W'(digit);
              last          <= (pos == '0);
              point_pending <= point_mode && (pos == POS_W'(2));
              if (pos == '0) begin
                state <= IDLE;
              end else begin
                pos <= pos - POS_W'(1);
              end
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/b2da_checker.sv
// Port-level assertions for the converter and their bind to the top level.
module b2da_checker
  import b2da_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic [VALUE_W-1:0]  value,
  input logic                two_decimals,
  input logic                item_valid,
  input logic                item_stall,
  input logic [CHAR_W-1:0]   character,
  input logic                last,
  input logic                char_valid,
  input logic                char_stall
);

`include "binary_to_decimal_ascii_unit_assert.svh"

  logic unused_payload;
  assign unused_payload = ^{value, two_decimals};

  // Only digits and the point ever leave the block.
  `B2DA_ASSERT_NOW(a_char_range, clk, rst, char_valid, (character == ASCII_POINT) || ((character >= ASCII_ZERO) && (character <= ASCII_NINE)))

  // The point is never the final character of a number.
  `B2DA_ASSERT_NOW(a_point_not_last, clk, rst, char_valid && (character == ASCII_POINT), !last)

  // A stalled output word holds.
  `B2DA_ASSERT_NEXT(a_out_hold, clk, rst, char_valid && char_stall, char_valid && $stable(character) && $stable(last))

  // An accepted word stalls the input after it is taken.
  `B2DA_ASSERT_NEXT(a_busy_after_accept, clk, rst, item_valid && !item_stall, item_stall)

endmodule

bind binary_to_decimal_ascii_unit b2da_checker u_checker (.*);
